// ----- design/lcc_pkg.sv -----
// lcc_pkg: types and constants shared by the load-cell container state classifier
// holds stand state codes, register indexes, item, config and result structs
// no dependencies
package lcc_pkg;

  localparam int unsigned WEIGHT_W   = 24;
  localparam int unsigned DELTA_W    = 23;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned VAR_W      = 32;
  localparam int unsigned VLIMIT_W   = 29;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [3:0] {
    ST_EMPTY    = 4'd0,
    ST_REMOVED  = 4'd1,
    ST_LIFT     = 4'd2,
    ST_UNSTABLE = 4'd3,
    ST_POURING  = 4'd4,
    ST_REFILL   = 4'd5,
    ST_CHANGING = 4'd6,
    ST_PRESENT  = 4'd7,
    ST_FAULT    = 4'd8
  } stand_state_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_DELTA   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_LIMIT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFT_WINDOW    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_LIMIT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_LIMIT  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POUR_DELTA     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_DELTA   = 4'd7;

  typedef struct packed {
    logic [DELTA_W-1:0]  motion_delta;
    logic [TIME_W-1:0]   settle_time;
    logic [DELTA_W-1:0]  empty_limit;
    logic [TIME_W-1:0]   lift_window;
    logic [VLIMIT_W-1:0] variance_limit;
    logic [DELTA_W-1:0]  present_limit;
    logic [DELTA_W-1:0]  pour_delta;
    logic [DELTA_W-1:0]  refill_delta;
  } lcc_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]          time_ms;
    logic [VAR_W-1:0]           variance;
    logic                       sensor_steady;
    logic                       signal_good;
    logic signed [WEIGHT_W-1:0] weight;
  } lcc_item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] held_stable_weight;
    logic                       settled;
    logic                       state_changed;
    stand_state_t               stand_state;
  } lcc_result_t;

endpackage

// ----- design/lcc_cfg_regs.sv -----
// lcc_cfg_regs: configuration register file of the classifier
// depends on lcc_pkg for register indexes and the config struct
module lcc_cfg_regs import lcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output lcc_cfg_t              cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motion_delta   <= 23'd16;
      cfg.settle_time    <= 32'd1000;
      cfg.empty_limit    <= 23'd320;
      cfg.lift_window    <= 32'd5000;
      cfg.variance_limit <= 29'd256;
      cfg.present_limit  <= 23'd1600;
      cfg.pour_delta     <= 23'd80;
      cfg.refill_delta   <= 23'd800;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MOTION_DELTA:   cfg.motion_delta   <= cfg_data[DELTA_W-1:0];
        CFG_SETTLE_TIME:    cfg.settle_time    <= cfg_data[TIME_W-1:0];
        CFG_EMPTY_LIMIT:    cfg.empty_limit    <= cfg_data[DELTA_W-1:0];
        CFG_LIFT_WINDOW:    cfg.lift_window    <= cfg_data[TIME_W-1:0];
        CFG_VARIANCE_LIMIT: cfg.variance_limit <= cfg_data[VLIMIT_W-1:0];
        CFG_PRESENT_LIMIT:  cfg.present_limit  <= cfg_data[DELTA_W-1:0];
        CFG_POUR_DELTA:     cfg.pour_delta     <= cfg_data[DELTA_W-1:0];
        CFG_REFILL_DELTA:   cfg.refill_delta   <= cfg_data[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/lcc_class_core.sv -----
// lcc_class_core: stand tracking state and the single-pass classification logic
// depends on lcc_pkg for the item, config and result structs
module lcc_class_core import lcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        commit,
  input  lcc_item_t   item,
  input  lcc_cfg_t    cfg,
  output lcc_result_t res
);

  stand_state_t               current_class, current_class_next;
  logic signed [WEIGHT_W-1:0] previous_weight;
  logic signed [WEIGHT_W-1:0] stable_weight, stable_weight_next;
  logic [TIME_W-1:0]          motion_time, motion_time_next;
  logic [TIME_W-1:0]          removal_time, removal_time_next;
  logic                       settled_flag, settled_flag_next;
  logic                       container_seen, container_seen_next;

  logic signed [WEIGHT_W:0]   diff;
  logic [WEIGHT_W:0]          diff_mag;
  logic                       moved;
  logic [TIME_W-1:0]          since_motion, since_removal;
  logic signed [WEIGHT_W+1:0] w_x, sw_x, present_x, empty_x, pour_x, refill_x;
  logic                       ref_ok, pour, refill, is_empty, at_present, var_big, lift;

  always_comb begin
    diff     = {item.weight[WEIGHT_W-1], item.weight}
             - {previous_weight[WEIGHT_W-1], previous_weight};
    diff_mag = diff[WEIGHT_W] ? (WEIGHT_W+1)'(-diff) : diff;
    moved    = (diff_mag > {2'b00, cfg.motion_delta}) || !item.sensor_steady;

    since_motion  = item.time_ms - motion_time;
    since_removal = item.time_ms - removal_time;

    w_x       = {{2{item.weight[WEIGHT_W-1]}}, item.weight};
    sw_x      = {{2{stable_weight[WEIGHT_W-1]}}, stable_weight};
    present_x = {3'b000, cfg.present_limit};
    empty_x   = {3'b000, cfg.empty_limit};
    pour_x    = sw_x - $signed({3'b000, cfg.pour_delta});
    refill_x  = sw_x + $signed({3'b000, cfg.refill_delta});

    ref_ok     = sw_x > present_x;
    pour       = ref_ok && (w_x < pour_x);
    refill     = ref_ok && (w_x > refill_x);
    is_empty   = w_x <= empty_x;
    at_present = w_x >= present_x;
    var_big    = item.variance > {cfg.variance_limit, 3'b000};
    lift       = (removal_time != '0) && (since_removal <= cfg.lift_window);
  end

  always_comb begin
    current_class_next  = current_class;
    stable_weight_next  = stable_weight;
    motion_time_next    = motion_time;
    removal_time_next   = removal_time;
    settled_flag_next   = settled_flag;
    container_seen_next = container_seen;
    if (!item.signal_good) begin
      current_class_next = ST_FAULT;
    end else begin
      if (moved) begin
        motion_time_next  = item.time_ms;
        settled_flag_next = 1'b0;
      end else if (since_motion >= cfg.settle_time) begin
        settled_flag_next = 1'b1;
      end
      if (is_empty) begin
        if (container_seen) begin
          current_class_next  = ST_REMOVED;
          container_seen_next = 1'b0;
          removal_time_next   = item.time_ms;
        end else begin
          current_class_next = ST_EMPTY;
        end
      end else if (!settled_flag_next) begin
        if (lift)         current_class_next = ST_LIFT;
        else if (var_big) current_class_next = ST_UNSTABLE;
        else if (pour)    current_class_next = ST_POURING;
        else if (refill)  current_class_next = ST_REFILL;
        else              current_class_next = ST_CHANGING;
        if (at_present) container_seen_next = 1'b1;
      end else begin
        if (at_present) begin
          container_seen_next = 1'b1;
          current_class_next  = refill ? ST_REFILL : ST_PRESENT;
          removal_time_next   = '0;
        end else begin
          current_class_next = ST_EMPTY;
        end
        stable_weight_next = item.weight;
      end
    end
  end

  always_comb begin
    res.stand_state        = current_class_next;
    res.state_changed      = current_class_next != current_class;
    res.settled            = settled_flag_next;
    res.held_stable_weight = stable_weight_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_class   <= ST_EMPTY;
      previous_weight <= '0;
      stable_weight   <= '0;
      motion_time     <= '0;
      removal_time    <= '0;
      settled_flag    <= 1'b0;
      container_seen  <= 1'b0;
    end else if (commit) begin
      current_class  <= current_class_next;
      stable_weight  <= stable_weight_next;
      motion_time    <= motion_time_next;
      removal_time   <= removal_time_next;
      settled_flag   <= settled_flag_next;
      container_seen <= container_seen_next;
      if (item.signal_good) previous_weight <= item.weight;
    end
  end

endmodule

// ----- design/load_cell_container_state_classifier.sv -----
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | s_axis_tdata, 96 bits, one reading
// m_axis   | out | m_axis_tvalid/m_axis_tready  | m_axis_tdata, 32 bits, one result
// cfg      | in  | cfg_valid/cfg_ready          | cfg_index 4 bits, cfg_data 32 bits
//
// one item per cycle sustained while m_axis is not stalled; an accepted item passes the
// input register, classification logic and result register, in that order, before its
// result shows on m_axis
// rst is synchronous; it clears the stand state and loads the register defaults
// a stall on m_axis holds the result register and backs up into the input register
// cfg_ready is always high; writes beyond index 7 are dropped
// depends on lcc_pkg, lcc_cfg_regs, lcc_class_core
module load_cell_container_state_classifier import lcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // weight[23:0], signal_good[24], sensor_steady[25], variance[57:26],
  // time_ms[89:58], zero pad [95:90]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // stand_state[3:0], state_changed[4], settled[5], held_stable_weight[29:6],
  // zero pad [31:30]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lcc_cfg_t    cfg;
  lcc_item_t   in_item;
  logic        in_valid;
  logic        advance;
  lcc_result_t res;
  lcc_result_t out_res;
  logic        out_valid;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_axis_tdata[$bits(lcc_item_t)-1:0];
    end
  end

  lcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcc_class_core u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (in_item),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(lcc_result_t))'(0), out_res};

endmodule

// ----- design/lcc_checker.sv -----
// lcc_checker: port-level assertions for the classifier, bound to the top level
// depends on lcc_pkg for port widths and state codes
module lcc_checker import lcc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  cfg_ready
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // nothing comes out right after reset
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // state code in range and padding zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= ST_FAULT && m_axis_tdata[31:30] == 2'b00)
    else $error("bad result encoding");

  // an item taken with an empty pipe shows up after the input and result registers
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("item lost in pipe");

  // config never blocks
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port stalled");

endmodule

bind load_cell_container_state_classifier lcc_checker u_lcc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);
